>>> rtl/uuid_key_hash_table_macros.svh
// Assertion macros for the uuid key hash table.
// Included by the top level; needs nothing else.
`ifndef UUID_KEY_HASH_TABLE_MACROS_SVH
`define UUID_KEY_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UKHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UKHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ukht_pkg.sv
// Shared types and constants for the uuid key hash table.
// Used by the controller, the datapath, the hash unit and the top level.
package ukht_pkg;

    localparam int KEY_W           = 64;
    localparam int OPCODE_W        = 2;
    localparam int STATUS_W        = 2;
    localparam int SLOT_W          = 12;
    localparam int CFG_W           = 4;
    localparam int LOG2_MIN        = 4;
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int MIX_SHIFT       = 33;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(12);

    localparam logic [KEY_W-1:0] MIX_A  = 64'hff51afd7ed558ccd;
    localparam logic [KEY_W-1:0] MIX_B  = 64'hc4ceb9fe1a85ec53;
    localparam logic [KEY_W-1:0] GOLDEN = 64'h9e3779b97f4a7c15;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_FOUND  = 2'd0,
        ST_FOUND      = 2'd1,
        ST_INSERTED   = 2'd2,
        ST_FULL_CLEAR = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    hash_start;
        logic    sweep_start;
        logic    sweep_step;
        logic    set_home;
        logic    probe_next;
        logic    ins_write;
        logic    set_result;
        logic    res_use_slot;
        t_status res_status;
        logic    out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hash_done;
        logic slot_valid;
        logic key_match;
        logic last_probe;
        logic sweep_last;
    } t_dp_stat;

    function automatic logic [KEY_W-1:0] fold33(input logic [KEY_W-1:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

>>> rtl/uuid_key_hash_table.sv
// Top level of the uuid key hash table: a linear-probing set of 192-bit keys
// with lookup, insert and clear. Built from ukht_ctrl and ukht_dp (ukht_pkg).
// One item is worked at a time. A lookup or insert hashes the key and then
// probes buckets: the hash's two finalizer rounds share one 32x32 multiplier
// over twelve partial products, and each probe costs a registered read of the
// single-port slot memory plus a compare. A clear sweeps the whole memory.
// After reset the same sweep runs with the input not ready; configuration
// writes are taken at any time. A finished result waits in an output register
// while the next item is taken.
`include "uuid_key_hash_table_macros.svh"

module uuid_key_hash_table
    import ukht_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [KEY_W-1:0]    i_key_high,
    input  logic [KEY_W-1:0]    i_key_low,
    input  logic [KEY_W-1:0]    i_key_digest,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    logic [CFG_W-1:0] r_size_log2;
    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_size_log2 <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    ukht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    ukht_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_size_log2  (r_size_log2),
        .i_key_high   (i_key_high),
        .i_key_low    (i_key_low),
        .i_key_digest (i_key_digest),
        .o_status     (o_status),
        .o_slot       (o_slot)
    );

    // Results without a bucket always carry slot zero.
    `UKHT_ASSERT_IMP(a_no_slot_zero, i_clk, i_rst_n, o_out_valid && (o_status == ST_NOT_FOUND || o_status == ST_FULL_CLEAR), o_slot == '0, "slot must be zero when no bucket is reported")

    // Only one item is in flight at a time.
    `UKHT_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input ready right after a transfer")

    // A lookup or insert cannot finish before the hash has run to its end.
    `UKHT_ASSERT_NXT(a_hash_len, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_opcode == OP_LOOKUP || i_opcode == OP_INSERT), !o_in_ready ##18 !o_in_ready, "probe work ended before the hash finished")

endmodule

>>> rtl/ukht_hash.sv
// Iterative bucket hash: two rounds of the 64-bit murmur finalizer.
// Each 64-bit product is built from three 32x32 partial products. Uses ukht_pkg.
module ukht_hash
    import ukht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key_high,
    input  logic [KEY_W-1:0] i_key_low,
    input  logic [KEY_W-1:0] i_key_digest,
    output logic             o_done,
    output logic [KEY_W-1:0] o_hash
);

    // Step 0 loads the mixer input; steps 1-4 multiply by MIX_A, 5-8 by MIX_B.
    localparam logic [3:0] STEP_LOAD = 4'd0;
    localparam logic [3:0] STEP_A0   = 4'd1;
    localparam logic [3:0] STEP_A1   = 4'd2;
    localparam logic [3:0] STEP_A2   = 4'd3;
    localparam logic [3:0] STEP_A3   = 4'd4;
    localparam logic [3:0] STEP_B0   = 4'd5;
    localparam logic [3:0] STEP_B1   = 4'd6;
    localparam logic [3:0] STEP_B2   = 4'd7;
    localparam logic [3:0] STEP_B3   = 4'd8;

    logic [KEY_W-1:0] r_v;
    logic [KEY_W-1:0] r_prod;
    logic [KEY_W-1:0] r_acc;
    logic [3:0]       r_step;
    logic             r_half;
    logic             r_busy;
    logic             r_done;

    logic [31:0]      w_mul_a;
    logic [31:0]      w_mul_b;
    logic [KEY_W-1:0] w_mul;
    logic [KEY_W-1:0] w_const;
    logic [KEY_W-1:0] w_mix_in;
    logic [KEY_W-1:0] w_fold;

    always_comb begin
        w_const  = (r_step < STEP_B0) ? MIX_A : MIX_B;
        w_mix_in = r_half ? (r_v ^ i_key_low ^ GOLDEN)
                          : (i_key_digest ^ i_key_high ^ GOLDEN);
        w_fold   = {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
        case (r_step)
            STEP_A0, STEP_B0: begin
                w_mul_a = r_v[31:0];
                w_mul_b = w_const[31:0];
            end
            STEP_A1, STEP_B1: begin
                w_mul_a = r_v[31:0];
                w_mul_b = w_const[63:32];
            end
            default: begin
                w_mul_a = r_v[63:32];
                w_mul_b = w_const[31:0];
            end
        endcase
    end

    assign w_mul = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_half <= 1'b0;
            r_step <= STEP_LOAD;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_half <= 1'b0;
                r_step <= STEP_LOAD;
            end else if (r_busy) begin
                if (r_step == STEP_B3) begin
                    r_step <= STEP_LOAD;
                    if (r_half) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_half <= 1'b1;
                    end
                end else begin
                    r_step <= r_step + 4'd1;
                end
            end
        end
    end

    // Low 64 bits of v*c = vL*cL + ((vL*cH + vH*cL) << 32).
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            case (r_step)
                STEP_LOAD: r_v <= fold33(w_mix_in);
                STEP_A0, STEP_B0: r_prod <= w_mul;
                STEP_A1, STEP_B1: begin
                    r_acc  <= r_prod;
                    r_prod <= w_mul;
                end
                STEP_A2, STEP_B2: begin
                    r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                    r_prod       <= w_mul;
                end
                STEP_A3, STEP_B3: r_v <= fold33(w_fold);
                default: ;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_hash = r_v;

endmodule

>>> rtl/ukht_dp.sv
// Datapath of the hash table: key registers, probe index, slot memory, result.
// Uses ukht_pkg and instantiates ukht_hash.
module ukht_dp
    import ukht_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [CFG_W-1:0]    i_size_log2,
    input  logic [KEY_W-1:0]    i_key_high,
    input  logic [KEY_W-1:0]    i_key_low,
    input  logic [KEY_W-1:0]    i_key_digest,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int LOG_W   = CFG_W + 1;
    localparam int ENTRY_W = 3 * KEY_W + 1;

    logic [KEY_W-1:0]    r_key_high;
    logic [KEY_W-1:0]    r_key_low;
    logic [KEY_W-1:0]    r_key_digest;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_cnt;
    logic [ENTRY_W-1:0]  r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]  r_rdata;
    logic [STATUS_W-1:0] r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]   r_slot;

    logic [CFG_W-1:0]    w_log2_sat;
    logic [LOG_W-1:0]    w_log2;
    logic [IDX_W-1:0]    w_mask;
    logic [KEY_W-1:0]    w_hash;
    logic                w_hash_done;
    logic                w_mem_we;
    logic [ENTRY_W-1:0]  w_mem_wdata;

    ukht_hash u_hash (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_cmd.hash_start),
        .i_key_high   (r_key_high),
        .i_key_low    (r_key_low),
        .i_key_digest (r_key_digest),
        .o_done       (w_hash_done),
        .o_hash       (w_hash)
    );

    // The active size is the register clamped to sixteen buckets below and
    // to the memory depth above.
    always_comb begin
        w_log2_sat = (i_size_log2 < CFG_W'(LOG2_MIN)) ? CFG_W'(LOG2_MIN) : i_size_log2;
        w_log2     = ({1'b0, w_log2_sat} > LOG_W'(IDX_W)) ? LOG_W'(IDX_W)
                                                          : {1'b0, w_log2_sat};
        for (int k = 0; k < IDX_W; k++) begin
            w_mask[k] = (LOG_W'(k) < w_log2);
        end
    end

    assign w_mem_we    = i_cmd.sweep_step | i_cmd.ins_write;
    assign w_mem_wdata = i_cmd.ins_write ? {1'b1, r_key_high, r_key_low, r_key_digest}
                                         : '0;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_idx] <= w_mem_wdata;
        end
        r_rdata <= r_mem[r_idx];
    end

    // The index starts at zero so the clearing pass after reset covers every slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.sweep_start) begin
            r_idx <= '0;
        end else if (i_cmd.sweep_step) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.set_home) begin
            r_idx <= w_hash[IDX_W-1:0] & w_mask;
        end else if (i_cmd.probe_next) begin
            r_idx <= (r_idx + 1'b1) & w_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key_high   <= i_key_high;
            r_key_low    <= i_key_low;
            r_key_digest <= i_key_digest;
        end
        if (i_cmd.set_home) begin
            r_cnt <= '0;
        end else if (i_cmd.probe_next) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.set_result) begin
            r_res_status <= i_cmd.res_status;
            r_res_slot   <= i_cmd.res_use_slot ? SLOT_W'(r_idx) : '0;
        end
        if (i_cmd.out_load) begin
            r_status <= r_res_status;
            r_slot   <= r_res_slot;
        end
    end

    always_comb begin
        o_stat.hash_done  = w_hash_done;
        o_stat.slot_valid = r_rdata[ENTRY_W-1];
        o_stat.key_match  = (r_rdata[ENTRY_W-2:0] == {r_key_high, r_key_low, r_key_digest});
        o_stat.last_probe = (r_cnt == w_mask);
        o_stat.sweep_last = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    end

    assign o_status = r_status;
    assign o_slot   = r_slot;

endmodule

>>> rtl/ukht_ctrl.sv
// Controller of the hash table: sequences hashing, probing, clearing and the
// result handshake. Uses ukht_pkg.
module ukht_ctrl
    import ukht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_dp_cmd             o_cmd,
    input  t_dp_stat            i_stat
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HASH   = 7'b0000100,
        S_READ   = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_insert;
    logic   n_insert;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state  = r_state;
        n_insert = r_insert;
        o_cmd    = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_insert   = (i_opcode == OP_INSERT);
                    case (t_opcode'(i_opcode))
                        OP_LOOKUP, OP_INSERT: begin
                            o_cmd.hash_start = 1'b1;
                            n_state          = S_HASH;
                        end
                        OP_CLEAR: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state           = S_CLEAR;
                        end
                        default: begin
                            o_cmd.set_result = 1'b1;
                            o_cmd.res_status = ST_NOT_FOUND;
                            n_state          = S_RESULT;
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    o_cmd.set_home = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_stat.slot_valid) begin
                    o_cmd.set_result = 1'b1;
                    if (r_insert) begin
                        o_cmd.ins_write    = 1'b1;
                        o_cmd.res_use_slot = 1'b1;
                        o_cmd.res_status   = ST_INSERTED;
                    end else begin
                        o_cmd.res_status = ST_NOT_FOUND;
                    end
                    n_state = S_RESULT;
                end else if (i_stat.key_match) begin
                    o_cmd.set_result   = 1'b1;
                    o_cmd.res_use_slot = 1'b1;
                    o_cmd.res_status   = ST_FOUND;
                    n_state            = S_RESULT;
                end else if (i_stat.last_probe) begin
                    // Every active bucket was visited without a hit or a hole.
                    o_cmd.set_result = 1'b1;
                    o_cmd.res_status = r_insert ? ST_FULL_CLEAR : ST_NOT_FOUND;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_READ;
                end
            end
            S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.res_status = ST_FULL_CLEAR;
                    n_state          = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_insert    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_insert    <= n_insert;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> bench/uuid_key_hash_table_tb.sv
`timescale 1ns / 1ps
// Testbench for uuid_key_hash_table: lookup, insert and clear transfers checked
// against an in-bench model of the linear-probing hash set. Needs ukht_pkg and the RTL.
module uuid_key_hash_table_tb;
    import ukht_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int KEY3_W = 3 * KEY_W;
    localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 64;
    localparam logic [KEY3_W-1:0] KEY_ONES = '1;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} t_rx_pattern;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
    } t_hash_result;

    // Keys are kept as {key_high, key_low, key_digest}.
    class t_hash_set_scoreboard;
        logic [CFG_W-1:0]  size_log2;
        bit                occupied[DEPTH];
        logic [KEY3_W-1:0] stored_keys[DEPTH];
        t_hash_result      pending[$];
        int                errors;

        function new();
            size_log2 = CFG_RESET;
            errors = 0;
            foreach (occupied[i]) occupied[i] = 1'b0;
        endfunction

        function logic [KEY_W-1:0] finalize(logic [KEY_W-1:0] v);
            v = v ^ (v >> MIX_SHIFT);
            v = v * MIX_A;
            v = v ^ (v >> MIX_SHIFT);
            v = v * MIX_B;
            return v ^ (v >> MIX_SHIFT);
        endfunction

        function logic [KEY_W-1:0] mix_word(logic [KEY_W-1:0] s, logic [KEY_W-1:0] w);
            return finalize(s ^ w ^ GOLDEN);
        endfunction

        // Out-of-range settings saturate, then shrink to fit the memory.
        function int unsigned bucket_count();
            int unsigned l;
            l = 32'(size_log2);
            if (l < LOG2_MIN) l = LOG2_MIN;
            while (l > LOG2_MIN && (1 << l) > DEPTH) l--;
            return 1 << l;
        endfunction

        function void note_item(logic [OPCODE_W-1:0] op, logic [KEY3_W-1:0] key);
            t_hash_result res;
            int unsigned  size;
            int unsigned  mask;
            int unsigned  b;
            int unsigned  idx;
            bit           done;
            res.status = ST_NOT_FOUND;
            res.slot = '0;
            if (op == OP_CLEAR) begin
                foreach (occupied[i]) occupied[i] = 1'b0;
                res.status = ST_FULL_CLEAR;
            end else if (op == OP_LOOKUP || op == OP_INSERT) begin
                size = bucket_count();
                mask = size - 1;
                b = 32'(mix_word(mix_word(key[KEY_W-1:0], key[KEY3_W-1:2*KEY_W]),
                                 key[2*KEY_W-1:KEY_W]) & mask);
                done = 1'b0;
                for (int n = 0; n < size && !done; n++) begin
                    idx = b % DEPTH;
                    if (!occupied[idx]) begin
                        if (op == OP_INSERT) begin
                            occupied[idx] = 1'b1;
                            stored_keys[idx] = key;
                            res.status = ST_INSERTED;
                            res.slot = SLOT_W'(idx);
                        end
                        done = 1'b1;
                    end else if (stored_keys[idx] == key) begin
                        res.status = ST_FOUND;
                        res.slot = SLOT_W'(idx);
                        done = 1'b1;
                    end else begin
                        b = (b + 1) & mask;
                    end
                end
                if (!done && op == OP_INSERT) res.status = ST_FULL_CLEAR;
            end
            pending.push_back(res);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl);
            t_hash_result exp_res;
            if (pending.size() == 0) begin
                $display("%0t: result with no item pending, status %0d slot %0d",
                         $time, st, sl);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (st !== exp_res.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, exp_res.status, st);
                errors++;
            end
            if (sl !== exp_res.slot) begin
                $display("%0t: slot mismatch, expected %0d, actual %0d",
                         $time, exp_res.slot, sl);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OPCODE_W-1:0] i_opcode;
    logic [KEY_W-1:0]    i_key_high;
    logic [KEY_W-1:0]    i_key_low;
    logic [KEY_W-1:0]    i_key_digest;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data;

    t_hash_set_scoreboard sb;
    logic [KEY3_W-1:0]  known_keys[$];
    t_rx_pattern        rx_mode = RX_RANDOM;
    bit                 gaps_on = 1'b0;
    int                 burst_left = 0;
    int                 hold_requests = 0;
    int                 hold_served = 0;
    int                 hold_left = 0;
    int                 rx_cycle = 0;

    uuid_key_hash_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_key_high  (i_key_high),
        .i_key_low   (i_key_low),
        .i_key_digest(i_key_digest),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: a long hold-off on request, otherwise the phase's stall pattern.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_mode == RX_ALWAYS) begin
            i_out_ready <= 1'b1;
        end else if (rx_mode == RX_RANDOM) begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_out_ready <= (rx_cycle % 7 < 4);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_status, o_slot);
        end
    end

    function automatic logic [KEY3_W-1:0] rand_key();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Offers one item and returns at the edge of its transfer, valid still high.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [KEY3_W-1:0] key);
        if (gaps_on) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_key_high <= key[KEY3_W-1:2*KEY_W];
        i_key_low <= key[2*KEY_W-1:KEY_W];
        i_key_digest <= key[KEY_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(op, key);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.size_log2 = value;
    endtask

    // Many operations reuse keys already seen, so probe chains and hits get exercised.
    task automatic random_item(input int clear_pct);
        int                r;
        int                bit_idx;
        logic [KEY3_W-1:0] key;
        r = $urandom_range(0, 99);
        key = rand_key();
        if (r < clear_pct) begin
            send_item(OP_CLEAR, key);
        end else if (r < clear_pct + 2) begin
            send_item(OP_NOP, key);
        end else if (r < 40 || known_keys.size() == 0) begin
            send_item(OP_INSERT, key);
            known_keys.push_back(key);
        end else begin
            key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            if (r < 55) begin
                send_item(OP_INSERT, key);
            end else if (r < 78) begin
                send_item(OP_LOOKUP, key);
            end else if (r < 90) begin
                // One flipped bit: same home bucket is unlikely, but the compare
                // of every word is exercised when it lands on a chain.
                bit_idx = $urandom_range(0, KEY3_W - 1);
                key[bit_idx] = ~key[bit_idx];
                send_item(OP_LOOKUP, key);
            end else begin
                send_item(OP_LOOKUP, rand_key());
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] size_cfg, input int n_items,
                             input int clear_pct, input t_rx_pattern rx,
                             input bit gaps, input bit hold, input bit mid_pause);
        wait_idle();
        write_size(size_cfg);
        rx_mode = rx;
        gaps_on = gaps;
        burst_left = 0;
        if (hold) hold_requests++;
        for (int i = 0; i < n_items; i++) begin
            if (mid_pause && i == n_items / 2) wait_idle();
            random_item(clear_pct);
        end
    endtask

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [KEY3_W-1:0] key;
        sb = new();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_opcode <= OP_LOOKUP;
        i_key_high <= '0;
        i_key_low <= '0;
        i_key_digest <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= CFG_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset table size.
        send_item(OP_LOOKUP, '0);
        send_item(OP_INSERT, KEY_ONES);
        send_item(OP_INSERT, '0);
        send_item(OP_LOOKUP, KEY_ONES);
        send_item(OP_INSERT, KEY_ONES);
        send_item(OP_LOOKUP, {{KEY_W{1'b1}}, {KEY_W{1'b0}}, {KEY_W{1'b1}}});
        send_item(OP_NOP, KEY_ONES);
        send_item(OP_CLEAR, KEY_ONES);
        send_item(OP_LOOKUP, KEY_ONES);

        // Smallest table: fill it, overflow it, and probe it end to end.
        wait_idle();
        write_size(4'd0);
        repeat (16) begin
            key = rand_key();
            send_item(OP_INSERT, key);
            known_keys.push_back(key);
        end
        send_item(OP_INSERT, rand_key());
        send_item(OP_LOOKUP, rand_key());
        send_item(OP_INSERT, known_keys[7]);

        run_phase(4'd15, 45, 3, RX_RANDOM,   1'b1, 1'b0, 1'b0);
        run_phase(4'd4,  45, 4, RX_PERIODIC, 1'b0, 1'b0, 1'b1);
        run_phase(4'd5,  45, 0, RX_ALWAYS,   1'b1, 1'b1, 1'b0);
        run_phase(4'd13, 45, 3, RX_PERIODIC, 1'b1, 1'b0, 1'b0);
        run_phase(4'd3,  45, 5, RX_RANDOM,   1'b0, 1'b0, 1'b0);
        run_phase(4'd12, 45, 3, RX_ALWAYS,   1'b0, 1'b0, 1'b1);
        run_phase(4'd7,  45, 3, RX_RANDOM,   1'b1, 1'b0, 1'b0);
        run_phase(4'd8,  45, 3, RX_PERIODIC, 1'b1, 1'b0, 1'b0);
        run_phase(CFG_W'($urandom_range(0, 15)), 45, 3, RX_RANDOM, 1'b1, 1'b0, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ukht_pkg.sv
rtl/ukht_hash.sv
rtl/ukht_dp.sv
rtl/ukht_ctrl.sv
rtl/uuid_key_hash_table.sv
bench/uuid_key_hash_table_tb.sv
